// ===== rtl/core/midi_note_pairing_unit_assert.svh =====
// ----------------------------------------------------------------------------
// midi note pairing assertion macros
// shared concurrent assertion forms, clocked on clk_i and gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_PAIRING_UNIT_ASSERT_SVH
`define MIDI_NOTE_PAIRING_UNIT_ASSERT_SVH

// same-cycle implication
`define MNP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mnp assertion failed");

// next-cycle implication
`define MNP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mnp assertion failed");

`endif

// ===== rtl/core/mnp_pkg.sv =====
// ----------------------------------------------------------------------------
// mnp_pkg
// field widths, constants and request codes of the note pairing unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mnp_pkg;

  // default table geometry
  localparam int unsigned MNP_CHANNELS = 16;
  localparam int unsigned MNP_KEYS     = 128;

  // field widths
  localparam int unsigned TYPE_W  = 3;
  localparam int unsigned DELTA_W = 28;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned KEY_W   = 7;
  localparam int unsigned VEL_W   = 7;
  localparam int unsigned PROG_W  = 7;
  localparam int unsigned TEMPO_W = 24;
  localparam int unsigned TICK_W  = 31;
  localparam int unsigned TRACK_W = 16;

  // generation tag kept with each sounding entry
  localparam int unsigned EPOCH_W = 4;

  localparam logic [TEMPO_W-1:0] TEMPO_RESET = TEMPO_W'(500000);
  localparam logic [TICK_W-1:0]  TICK_MAX    = '1;
  localparam logic [TRACK_W-1:0] TRACK_MAX   = '1;

  // request codes
  typedef enum logic [TYPE_W-1:0] {
    REQ_TRACK_START = 3'd0,
    REQ_NOTE_ON     = 3'd1,
    REQ_NOTE_OFF    = 3'd2,
    REQ_PROG_CHANGE = 3'd3,
    REQ_SET_TEMPO   = 3'd4,
    REQ_OTHER       = 3'd5
  } req_type_e;

endpackage

`default_nettype wire

// ===== rtl/core/mnp_req_if.sv =====
// ----------------------------------------------------------------------------
// mnp_req_if
// event channel into the note pairing unit, valid/ready with payload
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mnp_req_if;
  import mnp_pkg::*;

  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  req_type;
  logic [DELTA_W-1:0] delta_ticks;
  logic [CHAN_W-1:0]  chan;
  logic [KEY_W-1:0]   data_first;
  logic [VEL_W-1:0]   data_second;
  logic [TEMPO_W-1:0] tempo_value;
  logic               tempo_len_ok;

  modport source (
    output valid, req_type, delta_ticks, chan, data_first, data_second,
           tempo_value, tempo_len_ok,
    input  ready
  );

  modport sink (
    input  valid, req_type, delta_ticks, chan, data_first, data_second,
           tempo_value, tempo_len_ok,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/core/mnp_note_if.sv =====
// ----------------------------------------------------------------------------
// mnp_note_if
// completed note channel out of the note pairing unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mnp_note_if;
  import mnp_pkg::*;

  logic               valid;
  logic               ready;
  logic [KEY_W-1:0]   note_key;
  logic [CHAN_W-1:0]  note_chan;
  logic [TICK_W-1:0]  start_tick;
  logic [TICK_W-1:0]  length_ticks;
  logic [VEL_W-1:0]   note_velocity;
  logic [PROG_W-1:0]  chan_program;
  logic [TEMPO_W-1:0] current_tempo;
  logic [TRACK_W-1:0] track_number;

  modport source (
    output valid, note_key, note_chan, start_tick, length_ticks, note_velocity,
           chan_program, current_tempo, track_number,
    input  ready
  );

  modport sink (
    input  valid, note_key, note_chan, start_tick, length_ticks, note_velocity,
           chan_program, current_tempo, track_number,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/core/midi_note_pairing_unit.sv =====
// ----------------------------------------------------------------------------
// midi_note_pairing_unit
// pairs note-on and note-off events into completed notes with start and length
// ----------------------------------------------------------------------------
//
//   channel  dir  modport  contents
//   req_i    in   sink     decoded event: type, delta, channel, data, tempo
//   note_o   out  source   completed note: key, channel, start, length, extras
//
// one event per cycle unless stalled: sounding table read at accept, compare
// and write-back in the lookup stage, a same-address write forwarded to the read.
// a completed note sits in an output register; the event behind it stalls
// only when it completes a note too and the output is still not taken.
// after reset, and after every 2^EPOCH_W-th track start (16), the sounding
// table is swept clear over all CHANNELS*KEYS entries (2048), req_i.ready low.
// other track starts retire all sounding notes at once by bumping the epoch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module midi_note_pairing_unit #(
  parameter int unsigned CHANNELS = mnp_pkg::MNP_CHANNELS,
  parameter int unsigned KEYS     = mnp_pkg::MNP_KEYS
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  mnp_req_if.sink   req_i,
  mnp_note_if.source note_o
);
  import mnp_pkg::*;

  localparam int unsigned DEPTH    = CHANNELS * KEYS;
  localparam int unsigned ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CHAN_W:0] CHAN_LIM = (CHAN_W + 1)'(CHANNELS);
  localparam logic [KEY_W:0]  KEY_LIM  = (KEY_W + 1)'(KEYS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic               active;
    logic [TICK_W-1:0]  start;
    logic [VEL_W-1:0]   vel;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } mnp_state_e;

  // control state
  mnp_state_e         state_q, state_d;
  logic [ADDR_W-1:0]  clr_cnt_q, clr_cnt_d;
  logic [TICK_W-1:0]  abs_q, abs_d;
  logic [TRACK_W-1:0] track_q, track_d;
  logic [TEMPO_W-1:0] tempo_q, tempo_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [PROG_W-1:0]  prog_q [CHANNELS];
  logic [PROG_W-1:0]  prog_d [CHANNELS];

  // lookup stage
  logic               s1_valid_q, s1_valid_d;
  logic               s1_first_q;
  logic               s1_on_q;
  logic               s1_off_q;
  logic [ADDR_W-1:0]  s1_addr_q;
  logic [KEY_W-1:0]   s1_key_q;
  logic [CHAN_W-1:0]  s1_chan_q;
  logic [VEL_W-1:0]   s1_vel_q;
  logic [TICK_W-1:0]  s1_tick_q;
  logic [PROG_W-1:0]  s1_prog_q;
  logic [TEMPO_W-1:0] s1_tempo_q;
  logic [TRACK_W-1:0] s1_track_q;
  logic [EPOCH_W-1:0] s1_epoch_q;
  entry_t             hold_q;

  // forwarding of a write to the address read in the same cycle
  logic               fwd_hit_q;
  entry_t             fwd_data_q;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [KEY_W-1:0]   out_key_q;
  logic [CHAN_W-1:0]  out_chan_q;
  logic [TICK_W-1:0]  out_start_q;
  logic [TICK_W-1:0]  out_len_q;
  logic [VEL_W-1:0]   out_vel_q;
  logic [PROG_W-1:0]  out_prog_q;
  logic [TEMPO_W-1:0] out_tempo_q;
  logic [TRACK_W-1:0] out_track_q;

  // ram connections
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  entry_t             ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // combinational helpers
  logic               req_fire;
  logic               chan_ok;
  logic               key_ok;
  logic               pair_ok;
  logic               is_start;
  logic [TICK_W:0]    abs_sum;
  logic [TICK_W-1:0]  abs_adv;
  logic [TRACK_W-1:0] cur_track;
  logic [CH_IDX_W-1:0] ch_idx;
  entry_t             s1_entry;
  logic               hit;
  logic               out_free;
  logic               s1_adv;

  // request decode
  assign req_fire  = req_i.valid && req_i.ready;
  assign chan_ok   = {1'b0, req_i.chan} < CHAN_LIM;
  assign key_ok    = {1'b0, req_i.data_first} < KEY_LIM;
  assign pair_ok   = chan_ok && key_ok;
  assign is_start  = req_i.req_type == REQ_TRACK_START;
  assign ch_idx    = req_i.chan[CH_IDX_W-1:0];
  assign ram_raddr = ADDR_W'(32'(req_i.chan) * KEYS + 32'(req_i.data_first));

  // saturating time advance
  assign abs_sum   = {1'b0, abs_q} + (TICK_W + 1)'(req_i.delta_ticks);
  assign abs_adv   = abs_sum[TICK_W] ? TICK_MAX : abs_sum[TICK_W-1:0];
  assign cur_track = (track_q == '0) ? '0 : track_q - TRACK_W'(1);

  // looked-up entry: fresh read with forwarding, else the held copy
  always_comb begin
    if (!s1_first_q) begin
      s1_entry = hold_q;
    end else if (fwd_hit_q) begin
      s1_entry = fwd_data_q;
    end else begin
      s1_entry = entry_t'(ram_rdata);
    end
  end

  assign hit      = s1_valid_q && s1_off_q && s1_entry.active &&
                    (s1_entry.epoch == s1_epoch_q);
  assign out_free = !out_valid_q || note_o.ready;
  assign s1_adv   = s1_valid_q && (!hit || out_free);

  assign req_i.ready = (state_q == ST_RUN) && (!s1_valid_q || s1_adv);

  // table write: clearing sweep, note-on record or note-off retire
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s1_addr_q;
    ram_wdata = '0;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
    end else if (s1_adv && s1_on_q) begin
      ram_we          = 1'b1;
      ram_wdata.epoch = s1_epoch_q;
      ram_wdata.active = 1'b1;
      ram_wdata.start = s1_tick_q;
      ram_wdata.vel   = s1_vel_q;
    end else if (s1_adv && hit) begin
      ram_we = 1'b1;
    end
  end

  mnp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_mnp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // clearing sweep sequencer
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == LAST_ADDR) begin
          state_d   = ST_RUN;
          clr_cnt_d = '0;
        end else begin
          clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        end
      end
      ST_RUN: begin
        if (req_fire && is_start && (epoch_q == '1)) begin
          state_d = ST_CLEAR;
        end
      end
      default: begin
        state_d   = ST_CLEAR;
        clr_cnt_d = '0;
      end
    endcase
  end

  // per-event state update
  always_comb begin
    abs_d   = abs_q;
    track_d = track_q;
    tempo_d = tempo_q;
    epoch_d = epoch_q;
    prog_d  = prog_q;
    if (req_fire) begin
      if (is_start) begin
        abs_d   = '0;
        epoch_d = epoch_q + EPOCH_W'(1);
        for (int i = 0; i < CHANNELS; i++) begin
          prog_d[i] = '0;
        end
        if (track_q != TRACK_MAX) begin
          track_d = track_q + TRACK_W'(1);
        end
      end else begin
        abs_d = abs_adv;
        if ((req_i.req_type == REQ_PROG_CHANGE) && chan_ok) begin
          prog_d[ch_idx] = req_i.data_first;
        end
        if ((req_i.req_type == REQ_SET_TEMPO) && req_i.tempo_len_ok &&
            (cur_track == '0)) begin
          tempo_d = req_i.tempo_value;
        end
      end
    end
  end

  // lookup stage and output occupancy
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (req_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv && hit) begin
      out_valid_d = 1'b1;
    end else if (note_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      abs_q       <= '0;
      track_q     <= '0;
      tempo_q     <= TEMPO_RESET;
      epoch_q     <= '0;
      s1_valid_q  <= 1'b0;
      s1_first_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        prog_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      abs_q       <= abs_d;
      track_q     <= track_d;
      tempo_q     <= tempo_d;
      epoch_q     <= epoch_d;
      prog_q      <= prog_d;
      s1_valid_q  <= s1_valid_d;
      s1_first_q  <= req_fire;
      fwd_hit_q   <= ram_we && req_fire && (ram_waddr == ram_raddr);
      out_valid_q <= out_valid_d;
    end
  end

  // lookup stage payload, captured at accept
  always_ff @(posedge clk_i) begin
    hold_q     <= s1_entry;
    fwd_data_q <= ram_wdata;
    if (req_fire) begin
      s1_on_q    <= (req_i.req_type == REQ_NOTE_ON) && (req_i.data_second != '0) &&
                    pair_ok;
      s1_off_q   <= ((req_i.req_type == REQ_NOTE_OFF) ||
                     ((req_i.req_type == REQ_NOTE_ON) && (req_i.data_second == '0))) &&
                    pair_ok;
      s1_addr_q  <= ram_raddr;
      s1_key_q   <= req_i.data_first;
      s1_chan_q  <= req_i.chan;
      s1_vel_q   <= req_i.data_second;
      s1_tick_q  <= abs_adv;
      s1_prog_q  <= prog_q[ch_idx];
      s1_tempo_q <= tempo_q;
      s1_track_q <= cur_track;
      s1_epoch_q <= epoch_q;
    end
  end

  // completed note payload
  always_ff @(posedge clk_i) begin
    if (s1_adv && hit) begin
      out_key_q   <= s1_key_q;
      out_chan_q  <= s1_chan_q;
      out_start_q <= s1_entry.start;
      out_len_q   <= s1_tick_q - s1_entry.start;
      out_vel_q   <= s1_entry.vel;
      out_prog_q  <= s1_prog_q;
      out_tempo_q <= s1_tempo_q;
      out_track_q <= s1_track_q;
    end
  end

  assign note_o.valid         = out_valid_q;
  assign note_o.note_key      = out_key_q;
  assign note_o.note_chan     = out_chan_q;
  assign note_o.start_tick    = out_start_q;
  assign note_o.length_ticks  = out_len_q;
  assign note_o.note_velocity = out_vel_q;
  assign note_o.chan_program  = out_prog_q;
  assign note_o.current_tempo = out_tempo_q;
  assign note_o.track_number  = out_track_q;

endmodule

`default_nettype wire

// ===== rtl/core/mnp_ram.sv =====
// ----------------------------------------------------------------------------
// mnp_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mnp_ram #(
  parameter  int unsigned WIDTH  = 8,
  parameter  int unsigned DEPTH  = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/mnp_checker.sv =====
// ----------------------------------------------------------------------------
// mnp_checker
// port-level checks of the note pairing unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "midi_note_pairing_unit_assert.svh"

module mnp_checker #(
  parameter int unsigned CHANNELS = mnp_pkg::MNP_CHANNELS,
  parameter int unsigned KEYS     = mnp_pkg::MNP_KEYS
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         note_valid_i,
  input wire logic                         note_ready_i,
  input wire logic [mnp_pkg::KEY_W-1:0]    note_key_i,
  input wire logic [mnp_pkg::CHAN_W-1:0]   note_chan_i,
  input wire logic [mnp_pkg::TICK_W-1:0]   start_tick_i,
  input wire logic [mnp_pkg::TICK_W-1:0]   length_ticks_i,
  input wire logic [mnp_pkg::VEL_W-1:0]    note_velocity_i
);
  import mnp_pkg::*;

  // a stalled note keeps its place and its contents
  `MNP_ASSERT_NEXT(a_note_hold, note_valid_i && !note_ready_i, note_valid_i && $stable(note_key_i) && $stable(note_chan_i) && $stable(start_tick_i) && $stable(length_ticks_i))

  // only notes recorded with nonzero velocity complete
  `MNP_ASSERT_IMPLY(a_note_vel, note_valid_i, note_velocity_i != '0)

  // note end never passes the saturated tick limit
  `MNP_ASSERT_IMPLY(a_note_end, note_valid_i, (32'(start_tick_i) + 32'(length_ticks_i)) <= 32'(TICK_MAX))

  // completed notes come from table positions that exist
  `MNP_ASSERT_IMPLY(a_note_pos, note_valid_i, (32'(note_chan_i) < CHANNELS) && (32'(note_key_i) < KEYS))

endmodule

bind midi_note_pairing_unit mnp_checker #(
  .CHANNELS (CHANNELS),
  .KEYS     (KEYS)
) u_mnp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .note_valid_i    (note_o.valid),
  .note_ready_i    (note_o.ready),
  .note_key_i      (note_o.note_key),
  .note_chan_i     (note_o.note_chan),
  .start_tick_i    (note_o.start_tick),
  .length_ticks_i  (note_o.length_ticks),
  .note_velocity_i (note_o.note_velocity)
);

`default_nettype wire

// ===== verif/midi_note_pairing_unit_tb.sv =====
// ----------------------------------------------------------------------------
// midi_note_pairing_unit_tb
// self-checking bench for the note pairing unit: a directed event table, then
// random event streams built mostly from note-on/note-off pairs, with random
// stalls on both channels; every completed note is checked against the table
// or a behavioral tracker of tick time, sounding notes, programs and tempo
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midi_note_pairing_unit_tb;
  import mnp_pkg::*;

  localparam int unsigned SLOTS        = MNP_CHANNELS * MNP_KEYS;
  localparam int unsigned RANDOM_ITEMS = 625;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned CALM_AT      = 560;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  // selector codes beyond the named requests, they only advance time
  localparam logic [TYPE_W-1:0] SEL_RSVD6 = 3'd6;
  localparam logic [TYPE_W-1:0] SEL_RSVD7 = 3'd7;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [CHAN_W-1:0]  chan;
    logic [TICK_W-1:0]  start;
    logic [TICK_W-1:0]  length;
    logic [VEL_W-1:0]   vel;
    logic [PROG_W-1:0]  prog;
    logic [TEMPO_W-1:0] tempo;
    logic [TRACK_W-1:0] track;
  } note_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  kind;
    logic [DELTA_W-1:0] delta;
    logic [CHAN_W-1:0]  chan;
    logic [KEY_W-1:0]   key;
    logic [VEL_W-1:0]   vel;
    logic [TEMPO_W-1:0] tempo;
    logic               tempo_ok;
    logic               fixed;   // expected note typed into the table
    note_t              want;
  } midi_event_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mnp_req_if  req_bus ();
  mnp_note_if note_bus ();

  midi_note_pairing_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .note_o (note_bus)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // tracker state
  logic [TICK_W-1:0]  cur_tick = '0;
  bit                 note_live [SLOTS];
  logic [TICK_W-1:0]  note_start [SLOTS];
  logic [VEL_W-1:0]   note_vel [SLOTS];
  logic [PROG_W-1:0]  chan_prog [MNP_CHANNELS];
  logic [TEMPO_W-1:0] tempo_now = TEMPO_RESET;
  logic [TRACK_W-1:0] tracks_seen = '0;
  logic [10:0]        live_slots [$];

  note_t       pending_notes [$];
  midi_event_t directed_rows [$];

  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int unsigned stall_left = 0;
  bit          calm       = 1'b0;

  // advance the tracker by one event, returns 1 when a note completes
  function automatic bit pair_note_event(input midi_event_t ev, output note_t done);
    logic [31:0] sum;
    logic [10:0] slot;
    done = '0;
    if (ev.kind == REQ_TRACK_START) begin
      cur_tick = '0;
      foreach (note_live[i]) note_live[i] = 1'b0;
      foreach (chan_prog[i]) chan_prog[i] = '0;
      live_slots.delete();
      if (tracks_seen != TRACK_MAX) tracks_seen++;
      return 1'b0;
    end
    // time advance, saturating
    sum = 32'(cur_tick) + 32'(ev.delta);
    cur_tick = (sum > 32'(TICK_MAX)) ? TICK_MAX : sum[TICK_W-1:0];
    if (ev.kind == REQ_PROG_CHANGE) begin
      if (ev.chan < MNP_CHANNELS) chan_prog[ev.chan] = ev.key;
      return 1'b0;
    end
    if (ev.kind == REQ_SET_TEMPO) begin
      if (ev.tempo_ok && tracks_seen <= 1) tempo_now = ev.tempo;
      return 1'b0;
    end
    if ((ev.kind != REQ_NOTE_ON && ev.kind != REQ_NOTE_OFF) ||
        ev.chan >= MNP_CHANNELS || ev.key >= MNP_KEYS) return 1'b0;
    slot = 11'(ev.chan * MNP_KEYS + ev.key);
    // note on with velocity opens or overwrites the entry
    if (ev.kind == REQ_NOTE_ON && ev.vel != 0) begin
      if (!note_live[slot]) live_slots = {live_slots, slot};
      note_live[slot]  = 1'b1;
      note_start[slot] = cur_tick;
      note_vel[slot]   = ev.vel;
      return 1'b0;
    end
    if (!note_live[slot]) return 1'b0;
    // note off, or note on with zero velocity, closes it
    note_live[slot] = 1'b0;
    foreach (live_slots[i]) begin
      if (live_slots[i] == slot) begin
        live_slots.delete(i);
        break;
      end
    end
    done.key    = ev.key;
    done.chan   = ev.chan;
    done.start  = note_start[slot];
    done.length = cur_tick - note_start[slot];
    done.vel    = note_vel[slot];
    done.prog   = chan_prog[ev.chan];
    done.tempo  = tempo_now;
    done.track  = (tracks_seen == 0) ? '0 : tracks_seen - 1'b1;
    return 1'b1;
  endfunction

  // random event, mostly pairs on a narrow set of channels and keys
  function automatic midi_event_t random_event();
    midi_event_t ev;
    int unsigned pick;
    logic [10:0] slot;
    ev          = '0;
    ev.chan     = CHAN_W'($urandom);
    ev.key      = KEY_W'($urandom);
    ev.vel      = VEL_W'($urandom);
    ev.tempo    = TEMPO_W'($urandom);
    ev.tempo_ok = ($urandom_range(0, 3) != 0);
    pick = $urandom_range(0, 99);
    if (pick < 70)      ev.delta = DELTA_W'($urandom_range(0, 20));
    else if (pick < 90) ev.delta = DELTA_W'($urandom_range(0, 1000));
    else if (pick < 98) ev.delta = DELTA_W'($urandom);
    else                ev.delta = '1;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      ev.kind = REQ_TRACK_START;
    end else if (pick < 9) begin
      ev.kind = REQ_PROG_CHANGE;
    end else if (pick < 14) begin
      ev.kind = REQ_SET_TEMPO;
    end else if (pick < 17) begin
      ev.kind = TYPE_W'($urandom_range(REQ_OTHER, SEL_RSVD7));
    end else if (live_slots.size() != 0 && $urandom_range(0, 1) == 1) begin
      // close a sounding note
      slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
      ev.chan = slot[10:7];
      ev.key  = slot[6:0];
      if ($urandom_range(0, 3) == 0) begin
        ev.kind = REQ_NOTE_ON;
        ev.vel  = '0;
      end else begin
        ev.kind = REQ_NOTE_OFF;
      end
    end else begin
      // open a note, or a stray note off now and then
      ev.kind = ($urandom_range(0, 9) == 0) ? REQ_NOTE_OFF : REQ_NOTE_ON;
      if ($urandom_range(0, 7) != 0) begin
        ev.chan = CHAN_W'($urandom_range(0, 3));
        ev.key  = KEY_W'($urandom_range(60, 67));
      end
      if (ev.kind == REQ_NOTE_ON) ev.vel = VEL_W'($urandom_range(1, 127));
    end
    return ev;
  endfunction

  // one directed row
  task automatic add_row(input logic [TYPE_W-1:0] kind, input logic [DELTA_W-1:0] delta,
                         input logic [CHAN_W-1:0] chan, input logic [KEY_W-1:0] key,
                         input logic [VEL_W-1:0] vel, input logic [TEMPO_W-1:0] tempo,
                         input logic tempo_ok, input logic fixed, input note_t want);
    midi_event_t ev;
    ev.kind     = kind;
    ev.delta    = delta;
    ev.chan     = chan;
    ev.key      = key;
    ev.vel      = vel;
    ev.tempo    = tempo;
    ev.tempo_ok = tempo_ok;
    ev.fixed    = fixed;
    ev.want     = want;
    directed_rows = {directed_rows, ev};
  endtask

  // present one item, hold it until taken, then maybe idle
  task automatic send_event(input midi_event_t ev);
    note_t done;
    req_bus.valid        <= 1'b1;
    req_bus.req_type     <= ev.kind;
    req_bus.delta_ticks  <= ev.delta;
    req_bus.chan         <= ev.chan;
    req_bus.data_first   <= ev.key;
    req_bus.data_second  <= ev.vel;
    req_bus.tempo_value  <= ev.tempo;
    req_bus.tempo_len_ok <= ev.tempo_ok;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    if (pair_note_event(ev, done)) pending_notes = {pending_notes, (ev.fixed ? ev.want : done)};
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want)
      flag_mismatch($sformatf("note %s mismatch: expected %0d, got %0d", name, want, got));
  endfunction

  // note sink: random stall bursts, check on every taken item
  always @(posedge clk_i) begin
    note_t want;
    if (calm || !rst_ni) begin
      note_bus.ready <= 1'b1;
    end else if (stall_left != 0) begin
      note_bus.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      note_bus.ready <= 1'b0;
      stall_left = $urandom_range(0, 9);
    end else begin
      note_bus.ready <= 1'b1;
    end
    if (rst_ni && note_bus.valid === 1'b1 && note_bus.ready === 1'b1) begin
      if (pending_notes.size() == 0) begin
        flag_mismatch($sformatf("unexpected note: key %0d chan %0d",
                                note_bus.note_key, note_bus.note_chan));
      end else begin
        want = pending_notes.pop_front();
        check_field("key", 32'(want.key), 32'(note_bus.note_key));
        check_field("chan", 32'(want.chan), 32'(note_bus.note_chan));
        check_field("start", 32'(want.start), 32'(note_bus.start_tick));
        check_field("length", 32'(want.length), 32'(note_bus.length_ticks));
        check_field("velocity", 32'(want.vel), 32'(note_bus.note_velocity));
        check_field("program", 32'(want.prog), 32'(note_bus.chan_program));
        check_field("tempo", 32'(want.tempo), 32'(note_bus.current_tempo));
        check_field("track", 32'(want.track), 32'(note_bus.track_number));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    rst_ni               <= 1'b0;
    req_bus.valid        <= 1'b0;
    req_bus.req_type     <= REQ_OTHER;
    req_bus.delta_ticks  <= '0;
    req_bus.chan         <= '0;
    req_bus.data_first   <= '0;
    req_bus.data_second  <= '0;
    req_bus.tempo_value  <= '0;
    req_bus.tempo_len_ok <= 1'b0;
    foreach (chan_prog[i]) chan_prog[i] = '0;

    // directed table: extremes, every request, overwrite, saturation
    add_row(REQ_NOTE_ON, 0, 0, 0, 127, 0, 0, 0, '0);
    add_row(REQ_NOTE_OFF, 5, 0, 0, 33, 0, 0, 1,
            '{7'd0, 4'd0, 31'd0, 31'd5, 7'd127, 7'd0, TEMPO_RESET, 16'd0});
    add_row(REQ_PROG_CHANGE, 0, 15, 127, 0, 0, 0, 0, '0);
    add_row(REQ_NOTE_ON, 0, 15, 127, 1, 0, 0, 0, '0);
    // note on with zero velocity closes the note
    add_row(REQ_NOTE_ON, 10, 15, 127, 0, 0, 0, 1,
            '{7'd127, 4'd15, 31'd5, 31'd10, 7'd1, 7'd127, TEMPO_RESET, 16'd0});
    // note off with nothing sounding
    add_row(REQ_NOTE_OFF, 0, 3, 9, 0, 0, 0, 0, '0);
    // tempo with a bad length is dropped, a good one taken
    add_row(REQ_SET_TEMPO, 0, 0, 0, 0, 24'h000000, 0, 0, '0);
    add_row(REQ_SET_TEMPO, 0, 0, 0, 0, 24'hFFFFFF, 1, 0, '0);
    // second note on overwrites the first
    add_row(REQ_NOTE_ON, 0, 1, 64, 64, 0, 0, 0, '0);
    add_row(REQ_NOTE_ON, 3, 1, 64, 100, 0, 0, 0, '0);
    add_row(REQ_NOTE_OFF, 7, 1, 64, 0, 0, 0, 1,
            '{7'd64, 4'd1, 31'd18, 31'd7, 7'd100, 7'd0, 24'hFFFFFF, 16'd0});
    add_row(REQ_OTHER, 0, 0, 0, 0, 0, 0, 0, '0);
    add_row(SEL_RSVD6, 0, 0, 0, 0, 0, 0, 0, '0);
    add_row(SEL_RSVD7, 0, 0, 0, 0, 0, 0, 0, '0);
    // tick time runs into saturation under an open note
    add_row(REQ_NOTE_ON, 0, 2, 5, 10, 0, 0, 0, '0);
    for (int i = 0; i < 8; i++) add_row(REQ_OTHER, '1, 0, 0, 0, 0, 0, 0, '0);
    add_row(REQ_NOTE_OFF, '1, 2, 5, 0, 0, 0, 1,
            '{7'd5, 4'd2, 31'd25, 31'd2147483622, 7'd10, 7'd0, 24'hFFFFFF, 16'd0});
    add_row(REQ_TRACK_START, '1, 0, 0, 0, 0, 0, 0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) send_event(directed_rows[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // hold the sender until every completed note has come out
      if (i == HOLD_AT) begin
        req_bus.valid <= 1'b0;
        @(posedge clk_i);
        wait (pending_notes.size() == 0);
      end
      if (i == CALM_AT) calm = 1'b1;
      send_event(random_event());
    end

    // drain
    req_bus.valid <= 1'b0;
    wait (pending_notes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_notes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
